### rtl/rectified_block_averager_assert.svh
// Assertion macros shared by the rectified block averager RTL.
`ifndef RECTIFIED_BLOCK_AVERAGER_ASSERT_SVH
`define RECTIFIED_BLOCK_AVERAGER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define RBA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rba assertion failed");

// Antecedent implies consequent in the next cycle.
`define RBA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rba assertion failed");

`endif

### rtl/rba_pkg.sv
// Package with types and constants of the rectified block averager.
`timescale 1ns / 1ps

package rba_pkg;

	localparam int NUM_CHANNELS_DEF = 2;
	localparam int SAMPLE_BITS      = 12;
	localparam int CH_W             = 3;
	localparam int SUM_W            = 22;
	localparam int LEN_W            = 10;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 12;

	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

	localparam logic [LEN_W-1:0]       BLOCK_LENGTH_RST = 10'd50;
	localparam logic [SAMPLE_BITS-1:0] CENTER_CODE_RST  = 12'd2208;
	localparam logic [CH_W-1:0]        RECT_CHANNEL_RST = 3'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_CODE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RECT_CHANNEL = 2'd2;

	typedef struct packed {
		logic                   func;
		logic [CH_W-1:0]        channel;
		logic [SAMPLE_BITS-1:0] sample;
	} rba_req_t;

	typedef struct packed {
		logic [CH_W-1:0]        out_channel;
		logic [SAMPLE_BITS-1:0] rectified_sample;
		logic                   average_latched;
		logic [SAMPLE_BITS-1:0] filtered_value;
		logic                   filtered_ready;
		logic                   last;
	} rba_rsp_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rba_div_status_t;

endpackage

### rtl/rba_div.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rba_div #(
	parameter int DIVIDEND_W = rba_pkg::SUM_W,
	parameter int DIVISOR_W  = rba_pkg::LEN_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [DIVIDEND_W-1:0]        dividend,
	input  logic [DIVISOR_W-1:0]         divisor,
	output rba_pkg::rba_div_status_t     status,
	output logic [DIVIDEND_W-1:0]        quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0] trial;
	logic [DIVISOR_W:0] diff;
	logic               fits;

	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = quo_q;

endmodule

### rtl/rectified_block_averager.sv
// Top level of the rectified block averager: sequencer, channel stores, result register.
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//  req     | req_valid / req_ready   | req (func, channel, sample)
//  rsp     | rsp_valid / rsp_ready   | rsp (one per in-range sample, one per channel on collect)
//
// A sample that completes a block with no average pending goes through the shared divider,
// which produces one quotient bit a cycle over the 22-bit sum.
// Other samples go straight to the emit state; a collect steps through channels one by one.
// req_ready is low while an item is at work; cfg_ready is always high.
// A stalled rsp holds the output register and the sequencer waits for it.
// Reset clears all channel stores and loads the register defaults; no clearing pass.
`timescale 1ns / 1ps
`include "rectified_block_averager_assert.svh"

module rectified_block_averager #(
	parameter int NUM_CHANNELS = rba_pkg::NUM_CHANNELS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rba_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  rba_pkg::rba_req_t                req,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output rba_pkg::rba_rsp_t                rsp
);

	localparam int SB    = rba_pkg::SAMPLE_BITS;
	localparam int SUM_W = rba_pkg::SUM_W;
	localparam int LEN_W = rba_pkg::LEN_W;
	localparam int CH_W  = rba_pkg::CH_W;
	localparam int CH_IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;
	localparam logic [1:0] ST_COLL = 2'd3;

	logic [1:0] state_q;

	logic [LEN_W-1:0] blen_q;
	logic [SB-1:0]    center_q;
	logic [CH_W-1:0]  rect_ch_q;

	logic [SUM_W-1:0] sum_q   [NUM_CHANNELS];
	logic [LEN_W-1:0] count_q [NUM_CHANNELS];
	logic [SB-1:0]    avg_q   [NUM_CHANNELS];
	logic [SB-1:0]    filt_q  [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] pend_q;
	logic [NUM_CHANNELS-1:0] rdy_q;

	logic [CH_IW-1:0] coll_q;
	logic [CH_IW-1:0] ch_q;
	rba_pkg::rba_rsp_t res_q;
	rba_pkg::rba_rsp_t rsp_q;
	logic              rsp_valid_q;

	logic [CH_IW-1:0] idx;
	logic             in_range;
	logic [SB-1:0]    val;
	logic [SUM_W-1:0] sum_n;
	logic [LEN_W-1:0] cnt_n;
	logic [LEN_W-1:0] len_eff;
	logic             complete;
	logic             latch;
	logic             accept;
	logic             take_sample;
	logic             take_collect;
	logic             slot_free;
	logic             coll_step;
	logic             coll_last;
	logic [SB-1:0]    avg_sat;

	rba_pkg::rba_div_status_t div_st;
	logic [SUM_W-1:0]         div_quo;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blen_q    <= rba_pkg::BLOCK_LENGTH_RST;
			center_q  <= rba_pkg::CENTER_CODE_RST;
			rect_ch_q <= rba_pkg::RECT_CHANNEL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				rba_pkg::CFG_BLOCK_LENGTH: blen_q    <= cfg_data[LEN_W-1:0];
				rba_pkg::CFG_CENTER_CODE:  center_q  <= cfg_data[SB-1:0];
				rba_pkg::CFG_RECT_CHANNEL: rect_ch_q <= cfg_data[CH_W-1:0];
				default: ;
			endcase
		end
	end

	assign idx       = (state_q == ST_COLL) ? coll_q : req.channel[CH_IW-1:0];
	assign in_range  = {1'b0, req.channel} < (CH_W+1)'(NUM_CHANNELS);
	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign take_sample  = accept && !req.func && in_range;
	assign take_collect = accept && req.func;
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign coll_step = (state_q == ST_COLL) && slot_free;
	assign coll_last = (coll_q == CH_IW'(NUM_CHANNELS - 1));

	always_comb begin
		val = req.sample;
		if (req.channel == rect_ch_q) begin
			val = (req.sample > center_q) ? (req.sample - center_q) : (center_q - req.sample);
		end
	end

	assign sum_n    = sum_q[idx] + SUM_W'(val);
	assign cnt_n    = count_q[idx] + LEN_W'(1);
	assign len_eff  = (blen_q == '0) ? LEN_W'(1) : blen_q;
	assign complete = cnt_n >= len_eff;
	assign latch    = complete && !pend_q[idx];

	rba_div #(
		.DIVIDEND_W(SUM_W),
		.DIVISOR_W (LEN_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (take_sample && latch),
		.dividend(sum_n),
		.divisor (len_eff),
		.status  (div_st),
		.quotient(div_quo)
	);

	assign avg_sat = (div_quo[SUM_W-1:SB] != '0) ? rba_pkg::SAMPLE_MAX : div_quo[SB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			coll_q  <= '0;
			ch_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take_collect) begin
						coll_q  <= '0;
						state_q <= ST_COLL;
					end else if (take_sample) begin
						ch_q    <= idx;
						state_q <= latch ? ST_DIV : ST_EMIT;
					end
				end
				ST_DIV: begin
					if (div_st.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_COLL: begin
					if (coll_step) begin
						if (coll_last) begin
							state_q <= ST_IDLE;
						end else begin
							coll_q <= coll_q + CH_IW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				sum_q[c]   <= '0;
				count_q[c] <= '0;
				avg_q[c]   <= '0;
				filt_q[c]  <= '0;
			end
			pend_q <= '0;
			rdy_q  <= '0;
		end else begin
			if (take_sample) begin
				sum_q[idx]   <= complete ? '0 : sum_n;
				count_q[idx] <= complete ? '0 : cnt_n;
			end
			if (div_st.done) begin
				avg_q[ch_q]  <= avg_sat;
				pend_q[ch_q] <= 1'b1;
			end
			if (coll_step && pend_q[idx]) begin
				pend_q[idx] <= 1'b0;
				filt_q[idx] <= avg_q[idx];
				rdy_q[idx]  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_sample) begin
			res_q.out_channel      <= req.channel;
			res_q.rectified_sample <= val;
			res_q.average_latched  <= latch;
			res_q.filtered_value   <= filt_q[idx];
			res_q.filtered_ready   <= rdy_q[idx];
			res_q.last             <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && slot_free) begin
			rsp_q <= res_q;
		end else if (coll_step) begin
			rsp_q.out_channel      <= CH_W'(coll_q);
			rsp_q.rectified_sample <= '0;
			rsp_q.average_latched  <= 1'b0;
			rsp_q.filtered_value   <= pend_q[idx] ? avg_q[idx] : filt_q[idx];
			rsp_q.filtered_ready   <= pend_q[idx] | rdy_q[idx];
			rsp_q.last             <= coll_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT && slot_free) || coll_step) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`RBA_ASSERT_NOW(a_div_done_in_div, div_st.done, state_q == ST_DIV)
	`RBA_ASSERT_NOW(a_div_busy_in_div, div_st.busy, state_q == ST_DIV)
	`RBA_ASSERT_NEXT(a_div_leaves_to_emit, state_q == ST_DIV, state_q == ST_DIV || state_q == ST_EMIT)
	`RBA_ASSERT_NEXT(a_coll_end_idle, coll_step && coll_last, state_q == ST_IDLE && rsp_valid_q)

endmodule
